### hw/rtl/sgns_pkg.sv
// Shared constants, types and the sigmoid table for the embedding trainer.
package sgns_pkg;

    // Table geometry.
    localparam int VOCAB_SIZE      = 4096;
    localparam int HIDDEN_MAX      = 128;
    localparam int SIGMOID_ENTRIES = 1024;

    localparam int ROW_W  = 12;
    localparam int ELEM_W = 7;
    localparam int HID_W  = $clog2(HIDDEN_MAX);
    localparam int DIM_W  = $clog2(HIDDEN_MAX + 1);
    localparam int ADDR_W = $clog2(VOCAB_SIZE * HIDDEN_MAX);
    localparam int DEPTH  = VOCAB_SIZE * HIDDEN_MAX;
    localparam int SIG_W  = $clog2(SIGMOID_ENTRIES);
    localparam longint SIG_STEP = (64'sd1 <<< 28) / SIGMOID_ENTRIES;

    localparam int ACC_W  = 48;
    localparam int PROB_W = 25;
    localparam int LR_W   = 25;
    localparam int G_W    = 28;

    // Command codes.
    localparam logic [2:0] CMD_TRAIN    = 3'd0;
    localparam logic [2:0] CMD_WR_IN    = 3'd1;
    localparam logic [2:0] CMD_WR_OUT   = 3'd2;
    localparam logic [2:0] CMD_RD_IN    = 3'd3;
    localparam logic [2:0] CMD_RD_OUT   = 3'd4;

    // Configuration register indexes.
    localparam logic REG_DIMS = 1'b0;
    localparam logic REG_LR   = 1'b1;

    localparam logic [7:0]      DIMS_RESET = 8'd128;
    localparam logic [LR_W-1:0] LR_RESET   = 25'd419430;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_READ,
        S_DOT,
        S_DOT_DRAIN,
        S_SIG,
        S_GRAD,
        S_UPD,
        S_UPD_DRAIN,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic dot_issue;
        logic upd_issue;
        logic rd_issue;
        logic wr_en;
        logic sig_load;
        logic grad_load;
        logic finish;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_bad;
        logic is_write;
        logic is_read;
        logic dims_zero;
        logic walk_last;
        logic pipe_empty;
    } t_dp_stat;

    typedef logic [PROB_W-1:0] t_sig_rom [SIGMOID_ENTRIES];

    // Builds the sigmoid table at elaboration from a Taylor series of exp.
    function automatic t_sig_rom sig_rom_init();
        t_sig_rom    rom;
        longint      xs;
        logic [63:0] u, u2, u3, u4, y, d, num, rem, q, s;
        logic        neg;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            xs  = -(64'sd1 <<< 27) + longint'(i) * SIG_STEP;
            neg = (xs < 0);
            u   = neg ? 64'(-xs) : 64'(xs);
            u2  = (u * u) >> 32;
            u3  = (u2 * u) >> 32;
            u4  = (u3 * u) >> 32;
            y   = (64'd1 << 32) - u + (u2 >> 1) - u3 / 6 + u4 / 24;
            for (int k = 0; k < 8; k++) begin
                if (y >= (64'd1 << 32))
                    y = 64'd1 << 32;
                else
                    y = (y * y + (64'd1 << 31)) >> 32;
            end
            d   = (64'd1 << 32) + y;
            num = (64'd1 << 56) + (d >> 1);
            rem = '0;
            q   = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[b] = 1'b1;
                end
            end
            s = neg ? ((64'd1 << 24) - q) : q;
            rom[i] = s[PROB_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = sig_rom_init();

endpackage

### hw/rtl/sgns_ram.sv
// Generic simple dual-port RAM with registered read.
module sgns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re)
            r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sgns_ctrl.sv
// Controller state machine that sequences commands and training passes.
module sgns_ctrl
    import sgns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (start) n_state = S_DECODE;
            S_DECODE: begin
                priority if (i_stat.is_bad) n_state = S_FINISH;
                else if (i_stat.is_write)   n_state = S_WRITE;
                else if (i_stat.is_read)    n_state = S_READ;
                else if (i_stat.dims_zero)  n_state = S_DOT_DRAIN;
                else                        n_state = S_DOT;
            end
            S_WRITE:     n_state = S_FINISH;
            S_READ:      n_state = S_FINISH;
            S_DOT:       if (i_stat.walk_last) n_state = S_DOT_DRAIN;
            S_DOT_DRAIN: if (i_stat.pipe_empty) n_state = S_SIG;
            S_SIG:       n_state = S_GRAD;
            S_GRAD:      n_state = i_stat.dims_zero ? S_UPD_DRAIN : S_UPD;
            S_UPD:       if (i_stat.walk_last) n_state = S_UPD_DRAIN;
            S_UPD_DRAIN: if (i_stat.pipe_empty) n_state = S_FINISH;
            S_FINISH:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd           = '0;
        busy            = (r_state != S_IDLE);
        o_cmd.accept    = (r_state == S_IDLE) && start;
        o_cmd.dot_issue = (r_state == S_DOT);
        o_cmd.upd_issue = (r_state == S_UPD);
        o_cmd.rd_issue  = (r_state == S_READ);
        o_cmd.wr_en     = (r_state == S_WRITE);
        o_cmd.sig_load  = (r_state == S_SIG);
        o_cmd.grad_load = (r_state == S_GRAD);
        o_cmd.finish    = (r_state == S_FINISH);
    end

endmodule

### hw/rtl/sgns_dpath.sv
// Datapath: vector tables, dot product, sigmoid lookup and row update.
module sgns_dpath
    import sgns_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [LR_W-1:0]     i_cfg_wdata,
    input  logic [2:0]          i_cmd,
    input  logic [ROW_W-1:0]    i_word_in,
    input  logic [ROW_W-1:0]    i_word_out,
    input  logic [ELEM_W-1:0]   i_elem,
    input  logic signed [31:0]  i_weight_value,
    input  logic                i_label,
    input  t_ctrl_cmd           i_ctl,
    output t_dp_stat            o_stat,
    output logic                o_done,
    output logic signed [31:0]  o_read_value,
    output logic [PROB_W-1:0]   o_probability,
    output logic                o_status
);

    // Configuration registers.
    logic [7:0]      r_dims;
    logic [LR_W-1:0] r_lr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_RESET;
            r_lr   <= LR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_DIMS) r_dims <= i_cfg_wdata[7:0];
            if (i_cfg_addr == REG_LR)   r_lr   <= i_cfg_wdata;
        end
    end

    // Captured item.
    logic [2:0]         r_cmd;
    logic [ROW_W-1:0]   r_row_in, r_row_out;
    logic [ELEM_W-1:0]  r_elem;
    logic signed [31:0] r_wval;
    logic               r_label;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd     <= i_cmd;
            r_row_in  <= i_word_in;
            r_row_out <= i_word_out;
            r_elem    <= i_elem;
            r_wval    <= i_weight_value;
            r_label   <= i_label;
        end
    end

    // Decode and range checks.
    logic [DIM_W-1:0] dims_eff;
    logic             in_row_bad, out_row_bad, elem_bad, tab_out, is_train;
    logic             is_write, is_read;

    always_comb begin
        dims_eff    = (32'(r_dims) > HIDDEN_MAX) ? DIM_W'(HIDDEN_MAX) : DIM_W'(r_dims);
        in_row_bad  = (32'(r_row_in) >= VOCAB_SIZE);
        out_row_bad = (32'(r_row_out) >= VOCAB_SIZE);
        elem_bad    = (32'(r_elem) >= 32'(dims_eff));
        tab_out     = (r_cmd == CMD_WR_OUT) || (r_cmd == CMD_RD_OUT);
        is_train    = (r_cmd == CMD_TRAIN);
        is_write    = (r_cmd == CMD_WR_IN) || (r_cmd == CMD_WR_OUT);
        is_read     = (r_cmd == CMD_RD_IN) || (r_cmd == CMD_RD_OUT);
    end

    // Element counter for the two walks over the rows.
    logic [DIM_W-1:0] r_idx;
    logic             walk;

    assign walk = i_ctl.dot_issue || i_ctl.upd_issue;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept || i_ctl.grad_load)
            r_idx <= '0;
        else if (walk)
            r_idx <= r_idx + 1'b1;
    end

    // Pipeline control: stage 1 holds RAM data, stage 2 holds products.
    logic             r_v1, r_v2, r_u1, r_u2;
    logic [HID_W-1:0] r_e1, r_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= walk;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1 <= i_ctl.upd_issue;
        r_u2 <= r_u1;
        r_e1 <= r_idx[HID_W-1:0];
        r_e2 <= r_e1;
    end

    // Addresses.
    function automatic logic [ADDR_W-1:0] row_addr(logic [ROW_W-1:0] row,
                                                   logic [HID_W-1:0] e);
        return ADDR_W'(row) * ADDR_W'(HIDDEN_MAX) + ADDR_W'(e);
    endfunction

    logic [HID_W-1:0]  rd_e;
    logic [ADDR_W-1:0] rd_addr_in, rd_addr_out, wr_addr_in, wr_addr_out;
    logic              rd_en;

    always_comb begin
        rd_e        = walk ? r_idx[HID_W-1:0] : HID_W'(r_elem);
        rd_addr_in  = row_addr(r_row_in, rd_e);
        rd_addr_out = row_addr(r_row_out, rd_e);
        rd_en       = walk || i_ctl.rd_issue;
        wr_addr_in  = (r_v2 && r_u2) ? row_addr(r_row_in, r_e2)
                                     : row_addr(r_row_in, HID_W'(r_elem));
        wr_addr_out = (r_v2 && r_u2) ? row_addr(r_row_out, r_e2)
                                     : row_addr(r_row_out, HID_W'(r_elem));
    end

    // Vector tables.
    logic               we_in, we_out;
    logic signed [31:0] wd_in, wd_out, rd_in, rd_out;
    logic signed [31:0] upd_in, upd_out;

    always_comb begin
        we_in  = (r_v2 && r_u2) || (i_ctl.wr_en && (r_cmd == CMD_WR_IN));
        we_out = (r_v2 && r_u2) || (i_ctl.wr_en && (r_cmd == CMD_WR_OUT));
        wd_in  = (r_v2 && r_u2) ? upd_in : r_wval;
        wd_out = (r_v2 && r_u2) ? upd_out : r_wval;
    end

    sgns_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (we_in),
        .i_waddr (wr_addr_in),
        .i_wdata (wd_in),
        .i_re    (rd_en),
        .i_raddr (rd_addr_in),
        .o_rdata (rd_in)
    );

    sgns_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (we_out),
        .i_waddr (wr_addr_out),
        .i_wdata (wd_out),
        .i_re    (rd_en),
        .i_raddr (rd_addr_out),
        .o_rdata (rd_out)
    );

    // Stage 2 products: dot term and the two update terms.
    logic signed [G_W-1:0]    r_g;
    logic signed [63:0]       r_pdot;
    logic signed [G_W+31:0]   r_pin, r_pout;
    logic signed [31:0]       r_a2, r_b2;

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_pdot <= rd_in * rd_out;
            r_pin  <= r_g * rd_out;
            r_pout <= r_g * rd_in;
            r_a2   <= rd_in;
            r_b2   <= rd_out;
        end
    end

    // Saturating update values for the write-back.
    function automatic logic signed [31:0] sat32(logic signed [36:0] v);
        if (v > 37'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // The shifted products are signed; dropping the low bits floors them.
    always_comb begin
        upd_in  = sat32(37'(r_a2) + 37'($signed(r_pin[G_W+31:24])));
        upd_out = sat32(37'(r_b2) + 37'($signed(r_pout[G_W+31:24])));
    end

    // Dot product accumulator.
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept)
            r_acc <= '0;
        else if (r_v2 && !r_u2)
            r_acc <= r_acc + ACC_W'($signed(r_pdot[63:24]));
    end

    // Sigmoid lookup with saturation outside [-8, 8).
    logic [PROB_W-1:0]       r_p;
    logic signed [ACC_W-1:0] dsh;

    assign dsh = r_acc + (ACC_W'(1) <<< 27);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sig_load) begin
            priority if (r_acc < -(ACC_W'(1) <<< 27))
                r_p <= '0;
            else if (r_acc >= (ACC_W'(1) <<< 27))
                r_p <= PROB_W'(1) << 24;
            else
                r_p <= SIG_ROM[dsh[27 -: SIG_W]];
        end
    end

    // Gradient scale: (label - p) * learning_rate, floored.
    logic signed [25:0] diff;
    logic signed [51:0] gprod;

    always_comb begin
        diff  = r_label ? (26'sd16777216 - $signed({1'b0, r_p}))
                        : -$signed({1'b0, r_p});
        gprod = diff * $signed({1'b0, r_lr});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.grad_load)
            r_g <= gprod[51:24];
    end

    // Result register.
    logic                r_done, r_status;
    logic signed [31:0]  r_rv;
    logic [PROB_W-1:0]   r_prob;
    logic                bad;

    always_comb begin
        priority if (is_train)
            bad = in_row_bad || out_row_bad;
        else if (is_write || is_read)
            bad = (tab_out ? out_row_bad : in_row_bad) || elem_bad;
        else
            bad = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_done <= 1'b0;
        else
            r_done <= i_ctl.finish;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status <= bad;
            r_rv     <= (is_read && !bad) ? (tab_out ? rd_out : rd_in) : '0;
            r_prob   <= (is_train && !bad) ? r_p : '0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_read_value  = r_rv;
    assign o_probability = r_prob;

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.is_bad     = bad;
        o_stat.is_write   = is_write;
        o_stat.is_read    = is_read;
        o_stat.dims_zero  = (dims_eff == '0);
        o_stat.walk_last  = (r_idx == dims_eff - 1'b1);
        o_stat.pipe_empty = !r_v1 && !r_v2;
    end

endmodule

### hw/rtl/sgns_embedding_update.sv
// Top level of the skip-gram negative-sampling embedding trainer.
// Load and read items go through decode, one table access and finish before the o_done
// strobe; ignored items skip the table access. Training time grows with dims, set by one
// RAM read port per table walked once for the dot product and once for the update.
// One item at a time: start is taken only while busy is low; results cannot stall.
// Synchronous active-low reset clears control and config; tables are not cleared.
module sgns_embedding_update
    import sgns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [LR_W-1:0]    i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic [ROW_W-1:0]   i_word_in,
    input  logic [ROW_W-1:0]   i_word_out,
    input  logic [ELEM_W-1:0]  i_elem,
    input  logic signed [31:0] i_weight_value,
    input  logic               i_label,
    output logic               o_done,
    output logic signed [31:0] o_read_value,
    output logic [PROB_W-1:0]  o_probability,
    output logic               o_status
);

    t_ctrl_cmd ctl;
    t_dp_stat  stat;

    sgns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (ctl)
    );

    sgns_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (i_cmd),
        .i_word_in      (i_word_in),
        .i_word_out     (i_word_out),
        .i_elem         (i_elem),
        .i_weight_value (i_weight_value),
        .i_label        (i_label),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_probability  (o_probability),
        .o_status       (o_status)
    );

endmodule
